@@ design/owt_pkg.sv @@
// Shared types and command codes for the one-wire thermostat device.
// No dependencies; compile first.
`default_nettype none

package owt_pkg;

  // Command bytes understood by the device
  typedef enum logic [7:0] {
    CMD_WRITE_TH     = 8'h01,
    CMD_WRITE_TL     = 8'h02,
    CMD_WRITE_STATUS = 8'h0C,
    CMD_STOP_CONV    = 8'h22,
    CMD_LOAD_COUNTER = 8'h41,
    CMD_READ_COUNTER = 8'hA0,
    CMD_READ_TH      = 8'hA1,
    CMD_READ_TL      = 8'hA2,
    CMD_READ_TEMP    = 8'hAA,
    CMD_READ_STATUS  = 8'hAC,
    CMD_START_CONV   = 8'hEE
  } owt_cmd_e;

  // Kind of request
  localparam logic ACT_COMMAND = 1'b0;
  localparam logic ACT_EVENT   = 1'b1;

  typedef struct packed {
    logic              action;
    logic [7:0]        opcode;
    logic [7:0]        write_data;
    logic signed [7:0] measured_temp;
    logic [7:0]        measured_remain;
    logic [7:0]        measured_slope;
  } owt_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       bad_command;
    logic       converting;
  } owt_rsp_t;

endpackage

`default_nettype wire

@@ design/owt_core.sv @@
// Register file and command decoder of the thermostat device.
// Depends on owt_pkg.
`default_nettype none

module owt_core
  import owt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  owt_req_t req_i,
  output owt_rsp_t rsp_o
);

  logic       one_shot_q, one_shot_d;
  logic       polarity_q, polarity_d;
  logic       tmode_q, tmode_d;
  logic       low_flag_q, low_flag_d;
  logic       high_flag_q, high_flag_d;
  logic       done_q, done_d;
  logic       run_q, run_d;
  logic [7:0] limit_high_q, limit_high_d;
  logic [7:0] limit_low_q, limit_low_d;
  logic [7:0] temp_q, temp_d;
  logic [7:0] counter_q, counter_d;
  logic [7:0] slope_q, slope_d;
  logic [7:0] status;

  // Bit 5 (write in progress) reads 0, bit 6 reads 1
  assign status = {done_q, 1'b1, 1'b0, high_flag_q, low_flag_q,
                   tmode_q, polarity_q, one_shot_q};

  always_comb begin
    one_shot_d   = one_shot_q;
    polarity_d   = polarity_q;
    tmode_d      = tmode_q;
    low_flag_d   = low_flag_q;
    high_flag_d  = high_flag_q;
    done_d       = done_q;
    run_d        = run_q;
    limit_high_d = limit_high_q;
    limit_low_d  = limit_low_q;
    temp_d       = temp_q;
    counter_d    = counter_q;
    slope_d      = slope_q;
    rsp_o        = '0;

    if (req_i.action == ACT_EVENT) begin
      // Drop events that arrive while no conversion runs
      if (run_q) begin
        temp_d    = req_i.measured_temp;
        counter_d = req_i.measured_remain;
        slope_d   = req_i.measured_slope;
        if (req_i.measured_temp > $signed(limit_high_q)) high_flag_d = 1'b1;
        if (req_i.measured_temp < $signed(limit_low_q))  low_flag_d  = 1'b1;
        if (one_shot_q) begin
          run_d  = 1'b0;
          done_d = 1'b1;
        end
      end
    end else begin
      unique case (req_i.opcode)
        CMD_READ_TEMP: begin
          rsp_o.read_data  = temp_q;
          rsp_o.read_valid = 1'b1;
        end
        CMD_START_CONV: begin
          run_d  = 1'b1;
          done_d = 1'b0;
        end
        CMD_STOP_CONV: begin
          run_d  = 1'b0;
          done_d = 1'b1;
        end
        CMD_WRITE_TH: limit_high_d = req_i.write_data;
        CMD_WRITE_TL: limit_low_d  = req_i.write_data;
        CMD_READ_TH: begin
          rsp_o.read_data  = limit_high_q;
          rsp_o.read_valid = 1'b1;
        end
        CMD_READ_TL: begin
          rsp_o.read_data  = limit_low_q;
          rsp_o.read_valid = 1'b1;
        end
        CMD_WRITE_STATUS: begin
          one_shot_d  = req_i.write_data[0];
          polarity_d  = req_i.write_data[1];
          tmode_d     = req_i.write_data[2];
          low_flag_d  = req_i.write_data[3];
          high_flag_d = req_i.write_data[4];
        end
        CMD_READ_STATUS: begin
          rsp_o.read_data  = status;
          rsp_o.read_valid = 1'b1;
        end
        CMD_READ_COUNTER: begin
          rsp_o.read_data  = counter_q;
          rsp_o.read_valid = 1'b1;
        end
        CMD_LOAD_COUNTER: counter_d = slope_q;
        default: rsp_o.bad_command = 1'b1;
      endcase
    end

    rsp_o.converting = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_shot_q   <= 1'b0;
      polarity_q   <= 1'b0;
      tmode_q      <= 1'b0;
      low_flag_q   <= 1'b0;
      high_flag_q  <= 1'b0;
      done_q       <= 1'b1;
      run_q        <= 1'b0;
      limit_high_q <= '0;
      limit_low_q  <= '0;
      temp_q       <= '0;
      counter_q    <= '0;
      slope_q      <= '0;
    end else if (fire_i) begin
      one_shot_q   <= one_shot_d;
      polarity_q   <= polarity_d;
      tmode_q      <= tmode_d;
      low_flag_q   <= low_flag_d;
      high_flag_q  <= high_flag_d;
      done_q       <= done_d;
      run_q        <= run_d;
      limit_high_q <= limit_high_d;
      limit_low_q  <= limit_low_d;
      temp_q       <= temp_d;
      counter_q    <= counter_d;
      slope_q      <= slope_d;
    end
  end

endmodule

`default_nettype wire

@@ design/onewire_thermostat_device.sv @@
// Top level of the one-wire thermostat device: request register, core, response register.
// Depends on owt_pkg and owt_core.
//
//   Channel   Direction  Handshake                  Payload
//   request   in         in_valid_i / in_ready_o    in_req_i  (owt_req_t)
//   response  out        out_valid_o / out_ready_i  out_rsp_o (owt_rsp_t)
//
// One request is taken every cycle while the response is not stalled; each
// gives exactly one response. A request is accepted into the request register,
// then decoded, updating the state registers while loading the response register.
// Reset clears all status, limits and data registers (done bit set).
// A stalled response holds the response register; the request register
// still takes a new request while empty, then holds until the response
// register frees up.
`default_nettype none

module onewire_thermostat_device
  import owt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  owt_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output owt_rsp_t out_rsp_o
);

  logic     req_vld_q;
  owt_req_t req_q;
  logic     rsp_vld_q;
  owt_rsp_t rsp_q;
  owt_rsp_t rsp_d;
  logic     advance;

  // Advance the held request when the response register is empty or draining
  assign advance    = req_vld_q && (!rsp_vld_q || out_ready_i);
  assign in_ready_o = !req_vld_q || advance;

  // Request register: valid bit under reset, payload plain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      req_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  // State update happens only on the cycle the request advances
  owt_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .req_i  (req_q),
    .rsp_o  (rsp_d)
  );

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (!rsp_vld_q || out_ready_i) begin
      rsp_vld_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = rsp_vld_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

@@ design/owt_checker.sv @@
// Port-level checks for the thermostat device, bound to the top level.
// Depends on owt_pkg and onewire_thermostat_device.
`default_nettype none

module owt_checker
  import owt_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input owt_req_t in_req_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input owt_rsp_t out_rsp_o
);

  // A clock edge seen in reset is followed by no valid response
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("response valid during reset");

  // An unknown command returns no data
  a_bad_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.bad_command |->
      !out_rsp_o.read_valid && (out_rsp_o.read_data == 8'h00))
    else $error("bad command carries read data");

  // Data is zero unless flagged as a read response
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.read_valid |-> out_rsp_o.read_data == 8'h00)
    else $error("read data nonzero without read_valid");

  // Hold a stalled response
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response changed");

endmodule

bind onewire_thermostat_device owt_checker u_owt_checker (.*);

`default_nettype wire
